[rtl/core/ffpra_pkg.sv]
// Shared types, constants and codes for the first-fit page run allocator.
// No dependencies; every other file of the block but ffpra_mem refers to it by scoped names.
`timescale 1ns / 1ps

package ffpra_pkg;

  // Heap geometry defaults. The page size is a power of two.
  localparam int NUM_PAGES_DEF = 1024;
  localparam int PAGE_BYTES    = 4096;
  localparam int PAGE_SHIFT    = $clog2(PAGE_BYTES);

  // Fixed field widths of the request and result transfers.
  localparam int BYTES_W = 32;
  localparam int PAGE_FW = 10;
  localparam int RUN_FW  = 11;
  localparam int STAT_W  = 3;
  localparam int SMALL_W = 13;

  // Configuration port geometry.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_BLOCK_START = 2'd0;
  localparam logic [1:0] REG_BLOCK_LIMIT = 2'd1;
  localparam logic [1:0] REG_SMALL_LIMIT = 2'd2;

  // Request codes.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Reset value of the small request limit.
  localparam logic [SMALL_W-1:0] SMALL_LIMIT_RST = 13'd2048;

  typedef enum logic [STAT_W-1:0] {
    ST_ALLOCATED = 3'd0,
    ST_FREED     = 3'd1,
    ST_ZERO      = 3'd2,
    ST_SMALL     = 3'd3,
    ST_NOFIT     = 3'd4,
    ST_INVALID   = 3'd5,
    ST_BLOCKFREE = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SEARCH,
    S_MARK,
    S_FREE_RD,
    S_FREE_LEN,
    S_FREE_CLR,
    S_RESULT
  } state_t;

  // Configuration values as seen by the controller.
  typedef struct packed {
    logic [PAGE_FW-1:0] block_start;
    logic [PAGE_FW-1:0] block_limit;
    logic [SMALL_W-1:0] small_limit;
  } cfg_regs_t;

  // One result item.
  typedef struct packed {
    status_t            status;
    logic [PAGE_FW-1:0] start_page;
    logic [RUN_FW-1:0]  run_pages;
  } res_t;

endpackage

[rtl/core/first_fit_page_run_allocator.sv]
// First-fit page run allocator. After reset a clearing pass zeroes both page memories
// while in_stall stays high; configuration is taken. Refused or delegated requests
// go straight to the result; a free reads the recorded run length and clears the run;
// an allocate scans one page per cycle from the page region start, then marks
// each page of the run that it found.
// One request at a time; accepted while the last result waits.
`timescale 1ns / 1ps

module first_fit_page_run_allocator #(
  parameter int NUM_PAGES = ffpra_pkg::NUM_PAGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Request channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [ffpra_pkg::BYTES_W-1:0]  in_request_bytes,
  input  logic [ffpra_pkg::PAGE_FW-1:0]  in_free_page,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ffpra_pkg::STAT_W-1:0]   out_status,
  output logic [ffpra_pkg::PAGE_FW-1:0]  out_start_page,
  output logic [ffpra_pkg::RUN_FW-1:0]   out_run_pages,
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ffpra_pkg::CFG_AW-1:0]   paddr,
  input  logic [ffpra_pkg::CFG_DW-1:0]   pwdata,
  output logic [ffpra_pkg::CFG_DW-1:0]   prdata,
  output logic                           pready
);

  localparam int PW  = $clog2(NUM_PAGES);
  localparam int PCW = $clog2(NUM_PAGES + 1);

  ffpra_pkg::cfg_regs_t cfg;
  ffpra_pkg::res_t      res;
  ffpra_pkg::res_t      out_res_r;
  logic                 out_valid_r;
  logic                 push;
  logic                 slot_free;

  logic          tk_we;
  logic [PW-1:0] tk_waddr;
  logic          tk_wdata;
  logic [PW-1:0] tk_raddr;
  logic          tk_rdata;

  logic           rl_we;
  logic [PW-1:0]  rl_waddr;
  logic [PCW-1:0] rl_wdata;
  logic [PW-1:0]  rl_raddr;
  logic [PCW-1:0] rl_rdata;

  // Configuration registers.
  ffpra_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Per-page taken bits.
  ffpra_mem #(
    .DEPTH (NUM_PAGES),
    .WIDTH (1)
  ) u_taken_mem (
    .clk   (clk),
    .we    (tk_we),
    .waddr (tk_waddr),
    .wdata (tk_wdata),
    .raddr (tk_raddr),
    .rdata (tk_rdata)
  );

  // Run length recorded at each run's first page.
  ffpra_mem #(
    .DEPTH (NUM_PAGES),
    .WIDTH (PCW)
  ) u_runlen_mem (
    .clk   (clk),
    .we    (rl_we),
    .waddr (rl_waddr),
    .wdata (rl_wdata),
    .raddr (rl_raddr),
    .rdata (rl_rdata)
  );

  // Request sequencer.
  ffpra_ctrl #(
    .NUM_PAGES (NUM_PAGES)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_request_bytes (in_request_bytes),
    .in_free_page     (in_free_page),
    .slot_free        (slot_free),
    .push             (push),
    .res              (res),
    .tk_we            (tk_we),
    .tk_waddr         (tk_waddr),
    .tk_wdata         (tk_wdata),
    .tk_raddr         (tk_raddr),
    .tk_rdata         (tk_rdata),
    .rl_we            (rl_we),
    .rl_waddr         (rl_waddr),
    .rl_wdata         (rl_wdata),
    .rl_raddr         (rl_raddr),
    .rl_rdata         (rl_rdata)
  );

  // Output register: holds one result until its transfer completes.
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_res_r.status;
  assign out_start_page = out_res_r.start_page;
  assign out_run_pages  = out_res_r.run_pages;

`ifndef SYNTH
  // A result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && out_valid_r && out_stall))
    else $error("result pushed into a full output register");

  // A successful allocation always covers at least one page.
  a_alloc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ffpra_pkg::ST_ALLOCATED) |-> (out_run_pages != '0))
    else $error("allocation reported with zero pages");

  // The clearing pass blocks requests right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("request channel open before the clearing pass");
`endif

endmodule

[rtl/core/ffpra_mem.sv]
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// Holds the per-page taken bits and run lengths; uses no package items.
`timescale 1ns / 1ps

module ffpra_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/ffpra_cfg.sv]
// Configuration register file behind the APB-style port.
// Depends on ffpra_pkg for widths, register indexes and the cfg_regs_t type.
`timescale 1ns / 1ps

module ffpra_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ffpra_pkg::CFG_AW-1:0]     paddr,
  input  logic [ffpra_pkg::CFG_DW-1:0]     pwdata,
  output logic [ffpra_pkg::CFG_DW-1:0]     prdata,
  output logic                             pready,
  output ffpra_pkg::cfg_regs_t             cfg
);

  logic [ffpra_pkg::PAGE_FW-1:0] block_start_r;
  logic [ffpra_pkg::PAGE_FW-1:0] block_limit_r;
  logic [ffpra_pkg::SMALL_W-1:0] small_limit_r;
  logic [1:0]                    reg_idx;
  logic                          wr_xfer;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_xfer = psel && penable && pwrite;

  // Register writes on the access phase of a write transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_start_r <= '0;
      block_limit_r <= '0;
      small_limit_r <= ffpra_pkg::SMALL_LIMIT_RST;
    end else if (wr_xfer) begin
      case (reg_idx)
        ffpra_pkg::REG_BLOCK_START: block_start_r <= pwdata[ffpra_pkg::PAGE_FW-1:0];
        ffpra_pkg::REG_BLOCK_LIMIT: block_limit_r <= pwdata[ffpra_pkg::PAGE_FW-1:0];
        ffpra_pkg::REG_SMALL_LIMIT: small_limit_r <= pwdata[ffpra_pkg::SMALL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_idx)
      ffpra_pkg::REG_BLOCK_START: prdata = ffpra_pkg::CFG_DW'(block_start_r);
      ffpra_pkg::REG_BLOCK_LIMIT: prdata = ffpra_pkg::CFG_DW'(block_limit_r);
      ffpra_pkg::REG_SMALL_LIMIT: prdata = ffpra_pkg::CFG_DW'(small_limit_r);
      default:                    prdata = '0;
    endcase
  end

  assign cfg.block_start = block_start_r;
  assign cfg.block_limit = block_limit_r;
  assign cfg.small_limit = small_limit_r;

endmodule

[rtl/core/ffpra_ctrl.sv]
// Allocator sequencer: clearing pass, first-fit scan, run marking and release.
// Depends on ffpra_pkg; drives the ports of the two ffpra_mem instances.
`timescale 1ns / 1ps

module ffpra_ctrl #(
  parameter int NUM_PAGES = ffpra_pkg::NUM_PAGES_DEF,
  localparam int PW  = $clog2(NUM_PAGES),
  localparam int PCW = $clog2(NUM_PAGES + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ffpra_pkg::cfg_regs_t           cfg,
  // Request channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [ffpra_pkg::BYTES_W-1:0]  in_request_bytes,
  input  logic [ffpra_pkg::PAGE_FW-1:0]  in_free_page,
  // Result handoff to the output register.
  input  logic                           slot_free,
  output logic                           push,
  output ffpra_pkg::res_t                res,
  // Taken-bit memory.
  output logic                           tk_we,
  output logic [PW-1:0]                  tk_waddr,
  output logic                           tk_wdata,
  output logic [PW-1:0]                  tk_raddr,
  input  logic                           tk_rdata,
  // Run-length memory.
  output logic                           rl_we,
  output logic [PW-1:0]                  rl_waddr,
  output logic [PCW-1:0]                 rl_wdata,
  output logic [PW-1:0]                  rl_raddr,
  input  logic [PCW-1:0]                 rl_rdata
);

  localparam int NEED_FW = ffpra_pkg::BYTES_W + 1;

  ffpra_pkg::state_t state_r, state_nxt;
  logic [PCW-1:0]    ptr_r, ptr_nxt;
  logic [PCW-1:0]    chk_r, chk_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [PCW-1:0]    cnt_r, cnt_nxt;
  logic [PCW-1:0]    need_r, need_nxt;
  logic [PCW-1:0]    rem_r, rem_nxt;
  logic [PCW-1:0]    start_r, start_nxt;
  ffpra_pkg::res_t   res_r, res_nxt;

  logic               accept;
  logic [NEED_FW-1:0] need_full;
  logic [10:0]        first_page;
  logic [31:0]        first_ext;
  logic [31:0]        page_ext;
  logic [31:0]        bstart_ext;
  logic [31:0]        blimit_ext;
  logic [31:0]        start_ext;
  logic [31:0]        need_ext;
  logic [PCW-1:0]     run_start;
  logic [PCW-1:0]     cnt_inc;

  assign in_stall = (state_r != ffpra_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign res      = res_r;

  // Request decode helpers: page count rounded up, page region start, free bounds.
  assign need_full  = (NEED_FW'(in_request_bytes) + NEED_FW'(ffpra_pkg::PAGE_BYTES - 1))
                      >> ffpra_pkg::PAGE_SHIFT;
  assign first_page = {1'b0, cfg.block_limit} + 11'd1;
  assign first_ext  = 32'(first_page);
  assign page_ext   = 32'(in_free_page);
  assign bstart_ext = 32'(cfg.block_start);
  assign blimit_ext = 32'(cfg.block_limit);
  assign start_ext  = 32'(start_r);
  assign need_ext   = 32'(need_r);

  // Scan helpers: a free page either opens a run or extends the current one.
  assign run_start = (cnt_r == '0) ? chk_r : start_r;
  assign cnt_inc   = cnt_r + PCW'(1);

  // Read addresses follow the working pointers.
  assign tk_raddr = ptr_r[PW-1:0];
  assign rl_raddr = start_r[PW-1:0];

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ffpra_pkg::S_CLEAR;
      ptr_r     <= '0;
      chk_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ptr_r     <= ptr_nxt;
      chk_vld_r <= chk_vld_nxt;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    chk_r   <= chk_nxt;
    cnt_r   <= cnt_nxt;
    need_r  <= need_nxt;
    rem_r   <= rem_nxt;
    start_r <= start_nxt;
    res_r   <= res_nxt;
  end

  // Next state and memory commands.
  always_comb begin
    state_nxt   = state_r;
    ptr_nxt     = ptr_r;
    chk_nxt     = chk_r;
    chk_vld_nxt = 1'b0;
    cnt_nxt     = cnt_r;
    need_nxt    = need_r;
    rem_nxt     = rem_r;
    start_nxt   = start_r;
    res_nxt     = res_r;
    push        = 1'b0;
    tk_we       = 1'b0;
    tk_waddr    = ptr_r[PW-1:0];
    tk_wdata    = 1'b0;
    rl_we       = 1'b0;
    rl_waddr    = start_r[PW-1:0];
    rl_wdata    = '0;

    case (state_r)
      // Zero both memories one page per cycle after reset.
      ffpra_pkg::S_CLEAR: begin
        tk_we    = 1'b1;
        rl_we    = 1'b1;
        rl_waddr = ptr_r[PW-1:0];
        ptr_nxt  = ptr_r + PCW'(1);
        if (ptr_r == PCW'(NUM_PAGES - 1)) begin
          state_nxt = ffpra_pkg::S_IDLE;
        end
      end

      // Classify a new request; simple outcomes go straight to the result.
      ffpra_pkg::S_IDLE: begin
        res_nxt.start_page = '0;
        res_nxt.run_pages  = '0;
        if (accept) begin
          state_nxt = ffpra_pkg::S_RESULT;
          if (in_action == ffpra_pkg::ACT_ALLOC) begin
            if (in_request_bytes == '0) begin
              res_nxt.status = ffpra_pkg::ST_ZERO;
            end else if (in_request_bytes <= ffpra_pkg::BYTES_W'(cfg.small_limit)) begin
              res_nxt.status = ffpra_pkg::ST_SMALL;
            end else if (need_full > NEED_FW'(NUM_PAGES) || first_ext >= 32'(NUM_PAGES)) begin
              res_nxt.status = ffpra_pkg::ST_NOFIT;
            end else begin
              need_nxt  = need_full[PCW-1:0];
              ptr_nxt   = first_ext[PCW-1:0];
              cnt_nxt   = '0;
              state_nxt = ffpra_pkg::S_SEARCH;
            end
          end else begin
            if (page_ext >= bstart_ext && page_ext < blimit_ext) begin
              res_nxt.status = ffpra_pkg::ST_BLOCKFREE;
            end else if (page_ext > blimit_ext && page_ext < 32'(NUM_PAGES)) begin
              start_nxt = page_ext[PCW-1:0];
              state_nxt = ffpra_pkg::S_FREE_RD;
            end else begin
              res_nxt.status = ffpra_pkg::ST_INVALID;
            end
          end
        end
      end

      // Issue one taken-bit read per cycle; check the bit read the cycle before.
      ffpra_pkg::S_SEARCH: begin
        if (ptr_r < PCW'(NUM_PAGES)) begin
          chk_vld_nxt = 1'b1;
          chk_nxt     = ptr_r;
          ptr_nxt     = ptr_r + PCW'(1);
        end
        if (chk_vld_r) begin
          if (!tk_rdata) begin
            cnt_nxt   = cnt_inc;
            start_nxt = run_start;
            if (cnt_inc >= need_r) begin
              // Run found: record its length and start marking.
              rl_we       = 1'b1;
              rl_waddr    = run_start[PW-1:0];
              rl_wdata    = need_r;
              ptr_nxt     = run_start;
              rem_nxt     = need_r;
              chk_vld_nxt = 1'b0;
              state_nxt   = ffpra_pkg::S_MARK;
            end else if (chk_r == PCW'(NUM_PAGES - 1)) begin
              res_nxt.status     = ffpra_pkg::ST_NOFIT;
              res_nxt.start_page = '0;
              res_nxt.run_pages  = '0;
              state_nxt          = ffpra_pkg::S_RESULT;
            end
          end else begin
            cnt_nxt = '0;
            if (chk_r == PCW'(NUM_PAGES - 1)) begin
              res_nxt.status     = ffpra_pkg::ST_NOFIT;
              res_nxt.start_page = '0;
              res_nxt.run_pages  = '0;
              state_nxt          = ffpra_pkg::S_RESULT;
            end
          end
        end
      end

      // Set the taken bit of each page of the run.
      ffpra_pkg::S_MARK: begin
        tk_we    = 1'b1;
        tk_wdata = 1'b1;
        ptr_nxt  = ptr_r + PCW'(1);
        rem_nxt  = rem_r - PCW'(1);
        if (rem_r == PCW'(1)) begin
          res_nxt.status     = ffpra_pkg::ST_ALLOCATED;
          res_nxt.start_page = start_ext[ffpra_pkg::PAGE_FW-1:0];
          res_nxt.run_pages  = need_ext[ffpra_pkg::RUN_FW-1:0];
          state_nxt          = ffpra_pkg::S_RESULT;
        end
      end

      // Run-length read is in flight.
      ffpra_pkg::S_FREE_RD: begin
        state_nxt = ffpra_pkg::S_FREE_LEN;
      end

      // Take the recorded length and drop it from the memory.
      ffpra_pkg::S_FREE_LEN: begin
        need_nxt  = rl_rdata;
        rem_nxt   = rl_rdata;
        ptr_nxt   = start_r;
        rl_we     = 1'b1;
        state_nxt = ffpra_pkg::S_FREE_CLR;
      end

      // Clear taken bits of the run, stopping at the heap end.
      ffpra_pkg::S_FREE_CLR: begin
        if (rem_r == '0 || ptr_r == PCW'(NUM_PAGES)) begin
          res_nxt.status     = ffpra_pkg::ST_FREED;
          res_nxt.start_page = start_ext[ffpra_pkg::PAGE_FW-1:0];
          res_nxt.run_pages  = need_ext[ffpra_pkg::RUN_FW-1:0];
          state_nxt          = ffpra_pkg::S_RESULT;
        end else begin
          tk_we   = 1'b1;
          ptr_nxt = ptr_r + PCW'(1);
          rem_nxt = rem_r - PCW'(1);
        end
      end

      // Hand the result over once the output register has room.
      ffpra_pkg::S_RESULT: begin
        if (slot_free) begin
          push      = 1'b1;
          state_nxt = ffpra_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ffpra_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the first-fit page run allocator.
// Depends on ffpra_pkg and first_fit_page_run_allocator. It predicts each result
// from its own copy of the page tables and registers and checks every transfer.

module tb_top;

  localparam int NPAGES      = ffpra_pkg::NUM_PAGES_DEF;
  localparam int PBYTES      = ffpra_pkg::PAGE_BYTES;
  localparam int BW          = ffpra_pkg::BYTES_W;
  localparam int PFW         = ffpra_pkg::PAGE_FW;
  localparam int RFW         = ffpra_pkg::RUN_FW;
  localparam int SW          = ffpra_pkg::SMALL_W;
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int LONG_HOLD   = 400;
  localparam int MAX_REPORTS = 200;

  // One request with the outcome predicted for it.
  typedef struct {
    logic                  action;
    logic [BW-1:0]         bytes;
    logic [PFW-1:0]        page;
    bit                    after_idle;
    ffpra_pkg::res_t       outcome;
  } page_req_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_action = ffpra_pkg::ACT_ALLOC;
  logic [BW-1:0]                  in_request_bytes = '0;
  logic [PFW-1:0]                 in_free_page = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [ffpra_pkg::STAT_W-1:0]   out_status;
  logic [PFW-1:0]                 out_start_page;
  logic [RFW-1:0]                 out_run_pages;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [ffpra_pkg::CFG_AW-1:0]   paddr = '0;
  logic [ffpra_pkg::CFG_DW-1:0]   pwdata = '0;
  logic [ffpra_pkg::CFG_DW-1:0]   prdata;
  logic                           pready;

  // Predictor state: page tables and register copies.
  logic               taken_map [NPAGES];
  logic [RFW-1:0]     run_map   [NPAGES];
  logic [PFW-1:0]     shadow_block_start = '0;
  logic [PFW-1:0]     shadow_block_limit = '0;
  logic [SW-1:0]      shadow_small_limit = ffpra_pkg::SMALL_LIMIT_RST;

  page_req_t       request_q [$];
  ffpra_pkg::res_t pending_outcomes [$];
  int              live_runs [$];
  page_req_t       cur_req;
  logic            in_fire = 1'b0;

  int  sent_cnt = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  cfg_errors = 0;
  int  cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  settings_used = 1;
  int  n_alloc = 0;
  int  n_freed = 0;
  int  n_other = 0;
  int  pages_granted = 0;

  first_fit_page_run_allocator uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_request_bytes (in_request_bytes),
    .in_free_page     (in_free_page),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_start_page   (out_start_page),
    .out_run_pages    (out_run_pages),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #6 clk = ~clk;

  // Computes the outcome of one request and applies it to the page tables.
  function automatic ffpra_pkg::res_t page_run_outcome(logic action, logic [BW-1:0] bytes,
                                                       logic [PFW-1:0] page);
    ffpra_pkg::res_t r;
    longint unsigned need;
    int              first;
    int              run_start;
    int              count;
    int              p;
    int              len;
    bit              found;
    r = '0;
    found = 1'b0;
    run_start = 0;
    count = 0;
    if (action == ffpra_pkg::ACT_ALLOC) begin
      if (bytes == '0) begin
        r.status = ffpra_pkg::ST_ZERO;
      end else if (bytes <= shadow_small_limit) begin
        r.status = ffpra_pkg::ST_SMALL;
      end else begin
        need = (64'(bytes) + PBYTES - 1) / PBYTES;
        first = int'(shadow_block_limit) + 1;
        if (need > NPAGES || first >= NPAGES) begin
          r.status = ffpra_pkg::ST_NOFIT;
        end else begin
          // First fit: walk upward, restarting the run count at each taken page.
          for (p = first; p < NPAGES && !found; p++) begin
            if (!taken_map[p]) begin
              if (count == 0) run_start = p;
              count++;
              if (count >= need) found = 1'b1;
            end else begin
              count = 0;
            end
          end
          if (!found) begin
            r.status = ffpra_pkg::ST_NOFIT;
          end else begin
            for (p = run_start; p < run_start + int'(need); p++) taken_map[p] = 1'b1;
            run_map[run_start] = RFW'(need);
            r.status = ffpra_pkg::ST_ALLOCATED;
            r.start_page = PFW'(run_start);
            r.run_pages = RFW'(need);
          end
        end
      end
    end else if (page >= shadow_block_start && page < shadow_block_limit) begin
      r.status = ffpra_pkg::ST_BLOCKFREE;
    end else if (page > shadow_block_limit) begin
      // A page with no run recorded releases nothing.
      len = int'(run_map[page]);
      for (p = int'(page); p < int'(page) + len && p < NPAGES; p++) taken_map[p] = 1'b0;
      run_map[page] = '0;
      r.status = ffpra_pkg::ST_FREED;
      r.start_page = page;
      r.run_pages = RFW'(len);
    end else begin
      r.status = ffpra_pkg::ST_INVALID;
    end
    return r;
  endfunction

  // Predicts a request, tracks live runs and queues it for the driver.
  task automatic queue_request(logic action, logic [BW-1:0] bytes,
                               logic [PFW-1:0] page, bit after_idle);
    page_req_t req;
    int        idx;
    req.action = action;
    req.bytes = bytes;
    req.page = page;
    req.after_idle = after_idle;
    req.outcome = page_run_outcome(action, bytes, page);
    if (req.outcome.status == ffpra_pkg::ST_ALLOCATED) begin
      live_runs.push_back(int'(req.outcome.start_page));
      n_alloc++;
      pages_granted += int'(req.outcome.run_pages);
    end else if (req.outcome.status == ffpra_pkg::ST_FREED) begin
      n_freed++;
      for (idx = live_runs.size() - 1; idx >= 0; idx--) begin
        if (live_runs[idx] == int'(page)) live_runs.delete(idx);
      end
    end else begin
      n_other++;
    end
    request_q.push_back(req);
  endtask

  // Mostly allocate and free pairs on live runs, with refused and stray requests mixed in.
  task automatic queue_random_request();
    int unsigned    pick;
    int unsigned    k;
    int             idx;
    logic [BW-1:0]  b;
    logic [PFW-1:0] pg;
    bit             hold;
    pick = $urandom_range(0, 99);
    hold = ($urandom_range(0, 39) == 0);
    if (live_runs.size() > 48) pick = 50;
    if (pick >= 40 && pick < 70 && live_runs.size() == 0) pick = 0;
    if (pick < 40) begin
      if ($urandom_range(0, 59) == 0) k = $urandom_range(64, NPAGES);
      else if ($urandom_range(0, 9) == 0) k = $urandom_range(9, 64);
      else k = $urandom_range(1, 8);
      b = (k - 1) * PBYTES + $urandom_range(1, PBYTES);
      if (b <= shadow_small_limit) b = BW'(shadow_small_limit) + 32'd1;
      queue_request(ffpra_pkg::ACT_ALLOC, b, PFW'($urandom), hold);
    end else if (pick < 70) begin
      idx = $urandom_range(0, live_runs.size() - 1);
      pg = PFW'(live_runs[idx]);
      live_runs.delete(idx);
      queue_request(ffpra_pkg::ACT_FREE, $urandom, pg, hold);
    end else if (pick < 80) begin
      // Stray frees, half of them on the region boundaries.
      if ($urandom_range(0, 1) == 0) begin
        pg = PFW'($urandom);
      end else begin
        case ($urandom_range(0, 5))
          0: pg = shadow_block_start;
          1: pg = shadow_block_limit - 10'd1;
          2: pg = shadow_block_limit;
          3: pg = shadow_block_limit + 10'd1;
          4: pg = '0;
          default: pg = '1;
        endcase
      end
      queue_request(ffpra_pkg::ACT_FREE, $urandom, pg, hold);
    end else if (pick < 90) begin
      queue_request(ffpra_pkg::ACT_ALLOC, $urandom_range(0, shadow_small_limit),
                    PFW'($urandom), hold);
    end else begin
      queue_request(ffpra_pkg::ACT_ALLOC, $urandom, PFW'($urandom), hold);
    end
  endtask

  // Register write: setup cycle, then access cycle until pready, then read back.
  task automatic write_reg(logic [1:0] idx, int unsigned value);
    logic [ffpra_pkg::CFG_DW-1:0] want;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    case (idx)
      ffpra_pkg::REG_BLOCK_START: begin
        shadow_block_start = value[PFW-1:0];
        want = ffpra_pkg::CFG_DW'(shadow_block_start);
      end
      ffpra_pkg::REG_BLOCK_LIMIT: begin
        shadow_block_limit = value[PFW-1:0];
        want = ffpra_pkg::CFG_DW'(shadow_block_limit);
      end
      ffpra_pkg::REG_SMALL_LIMIT: begin
        shadow_small_limit = value[SW-1:0];
        want = ffpra_pkg::CFG_DW'(shadow_small_limit);
      end
      default: want = '0;
    endcase
    // The address is still on the port, so the register reads back here.
    if (prdata !== want) begin
      cfg_errors++;
      $display("%0t: register %0d read back: expected %0d, actual %0d",
               $time, idx, want, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Only called while the block is idle.
  task automatic apply_settings(int unsigned bs, int unsigned bl, int unsigned sl);
    write_reg(ffpra_pkg::REG_BLOCK_START, bs);
    write_reg(ffpra_pkg::REG_BLOCK_LIMIT, bl);
    write_reg(ffpra_pkg::REG_SMALL_LIMIT, sl);
    settings_used++;
    @(posedge clk);
  endtask

  // Waits until every queued request has been transferred and answered.
  task automatic wait_drained();
    do @(negedge clk);
    while (request_q.size() != 0 || in_valid || pending_outcomes.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(int unsigned bs, int unsigned bl, int unsigned sl, int n);
    int i;
    apply_settings(bs, bl, sl);
    for (i = 0; i < n; i++) queue_random_request();
    wait_drained();
  endtask

  // Request driver: a new transfer is offered only when none is pending.
  always @(negedge clk) begin
    bit idle;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      idle = (sent_cnt >= 150 && sent_cnt < 270) ? 1'b0 : ($urandom_range(0, 99) < 12);
      if (request_q.size() != 0 && !idle &&
          !(request_q[0].after_idle && pending_outcomes.size() != 0)) begin
        cur_req = request_q.pop_front();
        in_valid <= 1'b1;
        in_action <= cur_req.action;
        in_request_bytes <= cur_req.bytes;
        in_free_page <= cur_req.page;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall: one long hold-off, a window with no stalls, random stalls elsewhere.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 60) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else if (results_seen >= 150 && results_seen < 270) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 12);
    end
  end

  // Checks result transfers against the oldest outcome, then records request transfers.
  always @(posedge clk) begin
    ffpra_pkg::res_t want;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result: expected none, actual status %0d start %0d pages %0d",
                   $time, out_status, out_start_page, out_run_pages);
      end else begin
        want = pending_outcomes.pop_front();
        if ({out_status, out_start_page, out_run_pages} !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: expected status %0d start %0d pages %0d, %s %0d %0d %0d",
                     $time, want.status, want.start_page, want.run_pages,
                     "actual status/start/pages", out_status, out_start_page, out_run_pages);
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      pending_outcomes.push_back(cur_req.outcome);
      sent_cnt++;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d requests queued and %0d results outstanding",
               $time, request_q.size(), pending_outcomes.size());
      $display("FAIL first_fit_page_run_allocator");
      $finish;
    end
  end

  // Stimulus: directed cases under a few settings, then random phases.
  initial begin
    int i;
    for (i = 0; i < NPAGES; i++) begin
      taken_map[i] = 1'b0;
      run_map[i] = '0;
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: page region starts at page 1, small limit 2048 bytes.
    queue_request(ffpra_pkg::ACT_ALLOC, 32'd0, 10'h3FF, 1'b0);
    queue_request(ffpra_pkg::ACT_ALLOC, 32'd1, 10'h000, 1'b0);
    queue_request(ffpra_pkg::ACT_ALLOC, 32'd2048, 10'h3FF, 1'b0);
    queue_request(ffpra_pkg::ACT_ALLOC, 32'd2049, 10'h000, 1'b0);
    queue_request(ffpra_pkg::ACT_ALLOC, 32'd4096, 10'h3FF, 1'b0);
    queue_request(ffpra_pkg::ACT_ALLOC, 32'd4097, 10'h000, 1'b0);
    queue_request(ffpra_pkg::ACT_ALLOC, 32'hFFFF_FFFF, 10'h3FF, 1'b0);
    queue_request(ffpra_pkg::ACT_ALLOC, NPAGES * PBYTES, 10'h000, 1'b0);
    queue_request(ffpra_pkg::ACT_FREE, 32'hFFFF_FFFF, 10'd0, 1'b0);
    // Freeing inside a run releases nothing; then free each run and one twice.
    queue_request(ffpra_pkg::ACT_FREE, 32'd0, 10'd4, 1'b0);
    queue_request(ffpra_pkg::ACT_FREE, 32'hFFFF_FFFF, 10'd3, 1'b0);
    queue_request(ffpra_pkg::ACT_FREE, 32'd0, 10'd1, 1'b0);
    queue_request(ffpra_pkg::ACT_FREE, 32'd0, 10'd1, 1'b0);
    queue_request(ffpra_pkg::ACT_FREE, 32'hFFFF_FFFF, 10'd2, 1'b0);
    queue_request(ffpra_pkg::ACT_FREE, 32'd0, 10'd1023, 1'b0);
    // Whole page region in one run, then nothing fits.
    queue_request(ffpra_pkg::ACT_ALLOC, (NPAGES - 1) * PBYTES, 10'h3FF, 1'b0);
    queue_request(ffpra_pkg::ACT_ALLOC, 32'd4097, 10'h000, 1'b1);
    queue_request(ffpra_pkg::ACT_FREE, 32'd0, 10'd1, 1'b0);
    wait_drained();

    // Empty page region and a small limit of one page.
    apply_settings(0, NPAGES - 1, 4096);
    queue_request(ffpra_pkg::ACT_ALLOC, 32'd4096, 10'd0, 1'b0);
    queue_request(ffpra_pkg::ACT_ALLOC, 32'd4097, 10'd0, 1'b0);
    queue_request(ffpra_pkg::ACT_FREE, 32'd0, 10'd0, 1'b0);
    queue_request(ffpra_pkg::ACT_FREE, 32'd0, 10'd1022, 1'b0);
    queue_request(ffpra_pkg::ACT_FREE, 32'd0, 10'd1023, 1'b0);
    wait_drained();

    // Small limit of zero: one byte already needs a page.
    apply_settings(0, 0, 0);
    queue_request(ffpra_pkg::ACT_ALLOC, 32'd1, 10'd0, 1'b0);
    queue_request(ffpra_pkg::ACT_ALLOC, 32'd0, 10'd0, 1'b0);
    queue_request(ffpra_pkg::ACT_FREE, 32'd0, 10'd1, 1'b0);
    wait_drained();

    run_phase(0, 15, 2048, 100);
    run_phase(200, 100, 4096, 90);
    run_phase(5, 900, 1, 80);
    run_phase($urandom_range(0, NPAGES - 1), $urandom_range(0, 1000),
              $urandom_range(0, 4096), 70);
    run_phase($urandom_range(0, NPAGES - 1), $urandom_range(0, 1000),
              $urandom_range(0, 4096), 70);
    run_phase(NPAGES - 1, NPAGES - 2, 4096, 30);
    run_phase(0, 0, 2048, 110);

    // Give a stray late result time to show up.
    repeat (2 * NPAGES + 16) @(negedge clk);
    $display("Summary: %0d requests transferred and %0d results checked under %0d settings.",
             sent_cnt, results_seen, settings_used);
    $display("Summary: %0d allocations (%0d pages), %0d frees, %0d refused or delegated.",
             n_alloc, pages_granted, n_freed, n_other);
    if (mismatches == 0 && cfg_errors == 0 && pending_outcomes.size() == 0) begin
      $display("PASS first_fit_page_run_allocator");
    end else begin
      $display("FAIL first_fit_page_run_allocator");
    end
    $finish;
  end

endmodule
